/* src/clarke_park_transform_unit_defines.svh */
// Assertion macros shared by the transform unit sources.
`ifndef CLARKE_PARK_TRANSFORM_UNIT_DEFINES_SVH
`define CLARKE_PARK_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transform unit check failed");

// Next-cycle implication, checked out of reset.
`define CPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transform unit check failed");

`endif

/* src/cpt_pkg.sv */
// Shared types and constants of the Clarke/Park transform unit.
package cpt_pkg;

  localparam int DATA_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Sine/cosine format (Q1.15, independent of the data width)
  localparam int SINE_WIDTH = 16;
  localparam logic signed [SINE_WIDTH-1:0] SINE_MOST_NEG = 16'sh8000;

  // Sine pipeline: fold+scale, square, five series terms (two stages each), round
  localparam int N_ITER      = 5;
  localparam int SINE_STAGES = 2 * N_ITER + 3;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // Series divisors 110, 72, 42, 20, 6 as exact reciprocals: q = (v * m) >> k
  localparam logic [32:0] DIV_RECIP [N_ITER] = '{
    33'(((65'd1 << 39) + 65'd109) / 65'd110),
    33'(((65'd1 << 39) + 65'd71) / 65'd72),
    33'(((65'd1 << 38) + 65'd41) / 65'd42),
    33'(((65'd1 << 37) + 65'd19) / 65'd20),
    33'(((65'd1 << 35) + 65'd5) / 65'd6)
  };
  localparam int DIV_SHIFT [N_ITER] = '{39, 39, 38, 37, 35};

  // Transform constants, Q2.30, and rounding offsets
  localparam logic signed [31:0] INV_SQRT3_Q30  = 32'sd619925131;
  localparam logic signed [31:0] SQRT3_HALF_Q30 = 32'sd929887697;
  localparam logic signed [31:0] RND30          = 32'sd536870912;
  localparam logic signed [31:0] RND15          = 32'sd16384;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  // Values the sine series carries along its stages
  typedef struct packed {
    logic [31:0] x2;
    logic [30:0] x;
    logic        neg;
  } sine_carry_t;

endpackage

/* src/cpt_sine_pipe.sv */
// Pipelined quarter-wave sine evaluation by a fixed-point Taylor series.
module cpt_sine_pipe import cpt_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic [SINE_STAGES-1:0]       ld,
  input  logic [ANGLE_WIDTH-1:0]       angle,
  output logic signed [SINE_WIDTH-1:0] sine
);

  localparam int IW = ANGLE_WIDTH - 1;
  localparam logic [IW-1:0] QUARTER = IW'(1) << (ANGLE_WIDTH - 2);

  logic [1:0]    quad;
  logic [IW-1:0] r_ext;
  logic [IW-1:0] idx;

  logic [IW+31:0] prod_r;
  logic           neg0_r;
  logic [30:0]    x_r;
  logic [61:0]    xx_r;
  logic           neg1_r;

  logic [64:0]  q_r  [N_ITER];
  logic [61:0]  p_r  [N_ITER];
  sine_carry_t  cq_r [N_ITER];
  sine_carry_t  cp_r [N_ITER];

  logic [31:0]  v    [N_ITER];
  sine_carry_t  cin  [N_ITER];
  logic [30:0]  t    [N_ITER];
  logic [31:0]  mula [N_ITER];

  logic [31:0]  s;
  logic [32:0]  rs;
  logic [17:0]  q15;
  logic [15:0]  mag;
  logic signed [SINE_WIDTH-1:0] sine_r;

  // fold the angle onto the first quadrant
  always_comb begin
    quad  = angle[ANGLE_WIDTH-1 -: 2];
    r_ext = {1'b0, angle[ANGLE_WIDTH-3:0]};
    idx   = quad[0] ? (QUARTER - r_ext) : r_ext;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod_r <= (IW+32)'(idx) * (IW+32)'(PI_Q30);
      neg0_r <= quad[1];
    end
    if (ld[1]) begin
      x_r    <= prod_r[IW+30:IW];
      xx_r   <= 62'(prod_r[IW+30:IW]) * 62'(prod_r[IW+30:IW]);
      neg1_r <= neg0_r;
    end
  end

  // series term j: t = 1 - (x2 * t_prev) / div_j
  always_comb begin
    v[0]   = xx_r[61:30];
    cin[0] = '{x2: xx_r[61:30], x: x_r, neg: neg1_r};
    for (int j = 1; j < N_ITER; j++) begin
      v[j]   = p_r[j-1][61:30];
      cin[j] = cp_r[j-1];
    end
    for (int j = 0; j < N_ITER; j++) begin
      t[j]    = ONE_Q30 - 31'(q_r[j] >> DIV_SHIFT[j]);
      mula[j] = (j == N_ITER - 1) ? {1'b0, cq_r[j].x} : cq_r[j].x2;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N_ITER; j++) begin
      if (ld[2 + 2 * j]) begin
        q_r[j]  <= 65'(v[j]) * 65'(DIV_RECIP[j]);
        cq_r[j] <= cin[j];
      end
      if (ld[3 + 2 * j]) begin
        p_r[j]  <= 62'(mula[j]) * 62'(t[j]);
        cp_r[j] <= cq_r[j];
      end
    end
  end

  // s = x * t, rounded to Q1.15 and capped
  always_comb begin
    s   = p_r[N_ITER-1][61:30];
    rs  = 33'(s) + 33'(16384);
    q15 = rs[32:15];
    mag = (q15 > 18'd32767) ? 16'd32767 : q15[15:0];
  end

  always_ff @(posedge clk) begin
    if (ld[SINE_STAGES-1]) begin
      sine_r <= cp_r[N_ITER-1].neg ? -signed'(mag) : signed'(mag);
    end
  end

  assign sine = sine_r;

endmodule

/* src/cpt_sincos.sv */
// Sine/cosine pipeline with valid/ready stage control and payload sidecar.
`include "clarke_park_transform_unit_defines.svh"
module cpt_sincos import cpt_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [ANGLE_WIDTH-1:0]       in_rotor_angle,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output op_t                          out_op,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [SINE_WIDTH-1:0] out_sin,
  output logic signed [SINE_WIDTH-1:0] out_cos
);

  localparam int S = SINE_STAGES;

  typedef struct packed {
    op_t                         op;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
  } pay_t;

  logic [S-1:0] v_r;
  logic [S-1:0] v_nxt;
  logic [S-1:0] rdy;
  pay_t         pay_r [S];
  logic [ANGLE_WIDTH-1:0] cos_angle;

  // a stage may load when out_ready is high or some stage at or after it is empty
  for (genvar k = 0; k < S; k++) begin : g_rdy
    assign rdy[k] = out_ready || !(&v_r[S-1:k]);
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < S; k++) begin
      if (rdy[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pay_r[0] <= '{op: op_t'(in_opcode), x: in_x, y: in_y};
    end
    for (int k = 1; k < S; k++) begin
      if (rdy[k]) pay_r[k] <= pay_r[k-1];
    end
  end

  // cosine is sine a quarter turn ahead
  assign cos_angle = {in_rotor_angle[ANGLE_WIDTH-1 -: 2] + 2'd1,
                      in_rotor_angle[ANGLE_WIDTH-3:0]};

  cpt_sine_pipe #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sin (
    .clk   (clk),
    .ld    (rdy),
    .angle (in_rotor_angle),
    .sine  (out_sin)
  );

  cpt_sine_pipe #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cos (
    .clk   (clk),
    .ld    (rdy),
    .angle (cos_angle),
    .sine  (out_cos)
  );

  assign in_ready  = rdy[0];
  assign out_valid = v_r[S-1];
  assign out_op    = pay_r[S-1].op;
  assign out_x     = pay_r[S-1].x;
  assign out_y     = pay_r[S-1].y;

  `CPT_ASSERT_IMP(a_sine_no_most_neg, clk, rst_n, out_valid, (out_sin != SINE_MOST_NEG) && (out_cos != SINE_MOST_NEG))

endmodule

/* src/cpt_xform.sv */
// Four-stage Clarke/Park datapath with saturating output register.
`include "clarke_park_transform_unit_defines.svh"
module cpt_xform import cpt_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  op_t                          in_op,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  input  logic signed [SINE_WIDTH-1:0] in_sin,
  input  logic signed [SINE_WIDTH-1:0] in_cos,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_first,
  output logic signed [DATA_WIDTH-1:0] out_second,
  output logic signed [DATA_WIDTH-1:0] out_third
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = W + 5;
  localparam int NS = 4;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    priority if (v > SAT_HI) return SAT_HI[W-1:0];
    else if (v < SAT_LO)     return SAT_LO[W-1:0];
    else                     return v[W-1:0];
  endfunction

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;

  // stage 0
  op_t                         op0_r;
  logic signed [W+33:0]        bp0_r;
  logic signed [W+15:0]        xc0_r, ys0_r, xs0_r, yc0_r;
  logic signed [W-1:0]         x0_r;
  logic signed [SINE_WIDTH-1:0] sin0_r, cos0_r;
  logic signed [W+1:0]         s_sum;
  // stage 1
  op_t                         op1_r;
  logic signed [W+1:0]         alpha1_r, beta1_r;
  logic signed [SINE_WIDTH-1:0] sin1_r, cos1_r;
  logic signed [W+1:0]         beta_f, alpha_i, beta_i;
  // stage 2
  op_t                         op2_r;
  logic signed [W+1:0]         alpha2_r;
  logic signed [W+17:0]        ac2_r, bs2_r, bc2_r, as2_r;
  logic signed [W+33:0]        root2_r;
  // stage 3
  op_t                         op3_r;
  logic signed [W-1:0]         first_r, second_r, third_r;
  logic signed [W+18:0]        fwd_d, fwd_q;
  logic signed [W+34:0]        half, inv_b, inv_c;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_ready || !(&v_r[NS-1:k]);
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: beta numerator product, inverse Park products
  assign s_sum = (W+2)'(in_x) + ((W+2)'(in_y) <<< 1);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      op0_r  <= in_op;
      bp0_r  <= (W+34)'(s_sum) * (W+34)'(INV_SQRT3_Q30);
      xc0_r  <= (W+16)'(in_x) * (W+16)'(in_cos);
      ys0_r  <= (W+16)'(in_y) * (W+16)'(in_sin);
      xs0_r  <= (W+16)'(in_x) * (W+16)'(in_sin);
      yc0_r  <= (W+16)'(in_y) * (W+16)'(in_cos);
      x0_r   <= in_x;
      sin0_r <= in_sin;
      cos0_r <= in_cos;
    end
  end

  // stage 1: alpha and beta, rounded, unsaturated
  always_comb begin
    beta_f  = (W+2)'((bp0_r + (W+34)'(RND30)) >>> 30);
    alpha_i = (W+2)'(((W+17)'(xc0_r) - (W+17)'(ys0_r) + (W+17)'(RND15)) >>> 15);
    beta_i  = (W+2)'(((W+17)'(xs0_r) + (W+17)'(yc0_r) + (W+17)'(RND15)) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op1_r    <= op0_r;
      alpha1_r <= (op0_r == OP_INV) ? alpha_i : (W+2)'(x0_r);
      beta1_r  <= (op0_r == OP_INV) ? beta_i : beta_f;
      sin1_r   <= sin0_r;
      cos1_r   <= cos0_r;
    end
  end

  // stage 2: Park products, or beta * sqrt3/2
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      op2_r    <= op1_r;
      alpha2_r <= alpha1_r;
      ac2_r    <= (W+18)'(alpha1_r) * (W+18)'(cos1_r);
      bs2_r    <= (W+18)'(beta1_r) * (W+18)'(sin1_r);
      bc2_r    <= (W+18)'(beta1_r) * (W+18)'(cos1_r);
      as2_r    <= (W+18)'(alpha1_r) * (W+18)'(sin1_r);
      root2_r  <= (W+34)'(beta1_r) * (W+34)'(SQRT3_HALF_Q30);
    end
  end

  // stage 3: final sums, rounding, saturation
  always_comb begin
    fwd_d = (W+19)'(ac2_r) + (W+19)'(bs2_r) + (W+19)'(RND15);
    fwd_q = (W+19)'(bc2_r) - (W+19)'(as2_r) + (W+19)'(RND15);
    half  = (-((W+35)'(alpha2_r))) <<< 29;
    inv_b = (half + (W+35)'(root2_r) + (W+35)'(RND30)) >>> 30;
    inv_c = (half - (W+35)'(root2_r) + (W+35)'(RND30)) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      op3_r <= op2_r;
      if (op2_r == OP_INV) begin
        first_r  <= sat(SW'(alpha2_r));
        second_r <= sat(SW'(inv_b));
        third_r  <= sat(SW'(inv_c));
      end else begin
        first_r  <= sat(SW'(fwd_d >>> 15));
        second_r <= sat(SW'(fwd_q >>> 15));
        third_r  <= '0;
      end
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = v_r[NS-1];
  assign out_first  = first_r;
  assign out_second = second_r;
  assign out_third  = third_r;

  `CPT_ASSERT_IMP(a_fwd_third_zero, clk, rst_n, v_r[3] && (op3_r == OP_FWD), out_third == '0)
  `CPT_ASSERT_NXT(a_stage_advance, clk, rst_n, v_r[2] && rdy[3], v_r[3])

endmodule

/* src/clarke_park_transform_unit.sv */
// Clarke/Park transform unit top level: sine/cosine pipeline feeding the transform datapath.
//
// Field-oriented-control transform pipeline. Each word carries an opcode, a rotor
// angle (a full turn is 2^ANGLE_WIDTH) and two signed Q1.15 values. Opcode 0 runs
// forward Clarke on phases a and b (c implied) and then Park, giving d, q and zero.
// Opcode 1 runs inverse Park and then inverse Clarke, giving phases a, b and c.
// Sine and cosine are Q1.15, evaluated per word from a quarter-wave fold and a
// fixed-point series. Only the three results saturate. One word is accepted per
// clock and one result leaves per clock while out_ready does not stall the pipe;
// a word passes 13 stages of sine/cosine evaluation (quadrant fold and angle
// scaling, squaring, five series terms of two multiplies each, rounding) and then
// 4 transform stages (constant and rotation products, alpha/beta rounding, rotation
// or sqrt3/2 products, final sums with saturation). Every stage carries its own
// valid bit and holds its word under backpressure, so in_ready falls only when
// all stages are full and out_ready is low. No configuration, no tables, no
// start-up sweep: the block takes words right after reset.
`include "clarke_park_transform_unit_defines.svh"
module clarke_park_transform_unit import cpt_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [ANGLE_WIDTH-1:0]       in_rotor_angle,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_first,
  output logic signed [DATA_WIDTH-1:0] out_second,
  output logic signed [DATA_WIDTH-1:0] out_third
);

  // between sine/cosine stage and transform stage
  logic                          sc_valid;
  logic                          sc_ready;
  op_t                           sc_op;
  logic signed [DATA_WIDTH-1:0]  sc_x;
  logic signed [DATA_WIDTH-1:0]  sc_y;
  logic signed [SINE_WIDTH-1:0]  sc_sin;
  logic signed [SINE_WIDTH-1:0]  sc_cos;

  cpt_sincos #(
    .DATA_WIDTH  (DATA_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_sincos (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rotor_angle (in_rotor_angle),
    .in_x           (in_x),
    .in_y           (in_y),
    .out_valid      (sc_valid),
    .out_ready      (sc_ready),
    .out_op         (sc_op),
    .out_x          (sc_x),
    .out_y          (sc_y),
    .out_sin        (sc_sin),
    .out_cos        (sc_cos)
  );

  // the transform's last stage is the output register
  cpt_xform #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sc_valid),
    .in_ready   (sc_ready),
    .in_op      (sc_op),
    .in_x       (sc_x),
    .in_y       (sc_y),
    .in_sin     (sc_sin),
    .in_cos     (sc_cos),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third)
  );

  // with the output register empty, every stage can take a word
  `CPT_ASSERT_IMP(a_empty_out_takes_input, clk, rst_n, !out_valid, in_ready)

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Clarke/Park transform unit.
`timescale 1ns / 100ps

module testbench;
  import cpt_pkg::*;

  // Q2.30 transform constants and sine series values, kept apart from the RTL
  localparam longint unsigned SINE_PI_Q30 = 64'd3373259426;
  localparam longint unsigned SINE_ONE_Q30 = 64'd1073741824;
  localparam longint unsigned SERIES_DIV [5] = '{110, 72, 42, 20, 6};
  localparam longint INV_ROOT3_Q30 = 619925131;
  localparam longint HALF_ROOT3_Q30 = 929887697;
  localparam longint QUARTER_TURN = 16384;

  // Input word and result word as the ports carry them
  typedef struct packed {
    op_t                op;
    logic [15:0]        angle;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } foc_word_t;

  typedef struct packed {
    logic signed [15:0] first;
    logic signed [15:0] second;
    logic signed [15:0] third;
  } phase_triplet_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_opcode = 1'b0;
  logic [15:0]         in_rotor_angle = '0;
  logic signed [15:0]  in_x = '0;
  logic signed [15:0]  in_y = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  out_first;
  logic signed [15:0]  out_second;
  logic signed [15:0]  out_third;

  foc_word_t      stim_words[$];      // words still to be offered
  phase_triplet_t expected_phases[$]; // predictions of accepted words, oldest first
  foc_word_t      next_word;
  phase_triplet_t oldest_phase;
  int             words_sent = 0;
  int             results_seen = 0;
  int             mismatches = 0;

  clarke_park_transform_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rotor_angle (in_rotor_angle),
    .in_x           (in_x),
    .in_y           (in_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_first      (out_first),
    .out_second     (out_second),
    .out_third      (out_third)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Quarter-wave sine entry r (0..16384) in Q1.15: Taylor series in Q30, nested
  // from the highest term down, rounded to 15 bits and capped at +32767.
  function automatic longint quarter_sine_q15(longint unsigned r);
    longint unsigned ang_q30, ang_sq, term, prod, q15;
    ang_q30 = (r * SINE_PI_Q30) >> 15;
    ang_sq  = (ang_q30 * ang_q30) >> 30;
    term    = SINE_ONE_Q30;
    for (int i = 0; i < 5; i++)
      term = SINE_ONE_Q30 - ((ang_sq * term) >> 30) / SERIES_DIV[i];
    prod = (ang_q30 * term) >> 30;
    q15  = (prod + 64'd16384) >> 15;
    if (q15 > 64'd32767) q15 = 64'd32767;
    return longint'(q15);
  endfunction

  // Full-turn sine from the quarter wave: odd quadrants mirror, upper half negates
  function automatic longint sine_of(logic [15:0] angle);
    longint unsigned idx;
    longint v;
    idx = {50'd0, angle[13:0]};
    if (angle[14]) idx = QUARTER_TURN - idx;
    v = quarter_sine_q15(idx);
    return angle[15] ? -v : v;
  endfunction

  // Round half up (toward plus infinity) by 15 or 30 bits; >>> floors
  function automatic longint round15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic longint round30(longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [15:0] clamp_q15(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Expected result word for one accepted input word
  function automatic phase_triplet_t transform_word(foc_word_t w);
    longint sn, cs, xv, yv, alpha, beta, half, root, r1, r2, r3;
    phase_triplet_t res;
    sn = sine_of(w.angle);
    cs = sine_of(w.angle + 16'd16384);
    xv = w.x;
    yv = w.y;
    if (w.op == OP_FWD) begin
      // Clarke: alpha = a, beta = (a + 2b)/sqrt3, then Park rotation
      alpha = xv;
      beta  = round30((xv + 2 * yv) * INV_ROOT3_Q30);
      r1 = round15(alpha * cs + beta * sn);
      r2 = round15(beta * cs - alpha * sn);
      r3 = 0;
    end else begin
      // Inverse Park, then inverse Clarke around -alpha/2 +/- beta*sqrt3/2
      alpha = round15(xv * cs - yv * sn);
      beta  = round15(xv * sn + yv * cs);
      half  = -alpha * 64'sd536870912;
      root  = beta * HALF_ROOT3_Q30;
      r1 = alpha;
      r2 = round30(half + root);
      r3 = round30(half - root);
    end
    res.first  = clamp_q15(r1);
    res.second = clamp_q15(r2);
    res.third  = clamp_q15(r3);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_word(op_t op, logic [15:0] angle, logic signed [15:0] x,
                            logic signed [15:0] y);
    foc_word_t w;
    w.op = op;
    w.angle = angle;
    w.x = x;
    w.y = y;
    stim_words.push_back(w);
  endtask

  // Values at and next to the Q1.15 limits, where saturation and rounding bite
  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return 16'shffff;
      3: return 16'sh0000;
      4: return 16'sh0001;
      5: return 16'sh7fff;
      6: return 16'sh7ffe;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Angles on or next to the quadrant boundaries of the sine fold
  function automatic logic [15:0] edge_angle();
    logic [15:0] base;
    base = 16'($urandom_range(3)) << 14;
    return base + 16'($signed($urandom_range(4)) - 2);
  endfunction

  task automatic build_stimulus();
    logic signed [15:0] xv, yv;
    logic [15:0] ang;
    op_t op;
    // Directed: quadrant boundaries, all-ones angle, field extremes, both modes
    queue_word(OP_FWD, 16'd0,     16'sh0000, 16'sh0000);
    queue_word(OP_FWD, 16'd0,     16'sh7fff, 16'sh0000);
    queue_word(OP_FWD, 16'd16384, 16'sh7fff, 16'sh8000);
    queue_word(OP_FWD, 16'd32768, 16'sh8000, 16'sh7fff);
    queue_word(OP_FWD, 16'd49152, 16'sh8000, 16'sh8000);
    queue_word(OP_FWD, 16'd65535, 16'sh7fff, 16'sh7fff);
    queue_word(OP_FWD, 16'd8192,  16'sh7fff, 16'sh7fff);  // beta beyond range, d saturates
    queue_word(OP_FWD, 16'd40960, 16'sh8000, 16'sh8000);  // d saturates high as well
    queue_word(OP_FWD, 16'd1,     16'shffff, 16'sh0001);
    queue_word(OP_FWD, 16'd16383, 16'sh0001, 16'shffff);
    queue_word(OP_INV, 16'd0,     16'sh7fff, 16'sh0000);
    queue_word(OP_INV, 16'd0,     16'sh0000, 16'sh7fff);
    queue_word(OP_INV, 16'd16384, 16'sh8000, 16'sh7fff);
    queue_word(OP_INV, 16'd32768, 16'sh7fff, 16'sh8000);
    queue_word(OP_INV, 16'd49152, 16'sh8000, 16'sh8000);
    queue_word(OP_INV, 16'd65535, 16'sh7fff, 16'sh7fff);
    queue_word(OP_INV, 16'd8192,  16'sh7fff, 16'sh7fff);  // phase b saturates high
    queue_word(OP_INV, 16'd40960, 16'sh8000, 16'sh8000);  // phase b saturates high, phase c low
    queue_word(OP_INV, 16'd24576, 16'sh7fff, 16'sh7fff);  // phase c side
    queue_word(OP_INV, 16'd1,     16'shffff, 16'sh0001);
    queue_word(OP_INV, 16'd32767, 16'sh0000, 16'sh0000);
    // Random: mostly full range, some edge values and boundary angles
    for (int n = 0; n < 900; n++) begin
      op  = $urandom_range(1) ? OP_INV : OP_FWD;
      ang = ($urandom_range(4) == 0) ? edge_angle() : 16'($urandom_range(65535));
      if ($urandom_range(4) == 0) begin
        xv = edge_value();
        yv = edge_value();
      end else begin
        xv = 16'($urandom_range(65535));
        yv = 16'($urandom_range(65535));
      end
      queue_word(op, ang, xv, yv);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, predicts each word at its accept edge.
  // Gaps in about 25 percent of cycles, none while words 300..549 go out.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_word.op    = op_t'(in_opcode);
        next_word.angle = in_rotor_angle;
        next_word.x     = in_x;
        next_word.y     = in_y;
        expected_phases.push_back(transform_word(next_word));
        words_sent++;
      end
      // A held word stays put until accepted; otherwise load the next or gap
      if (!in_valid || in_ready) begin
        if (stim_words.size() != 0 &&
            ((words_sent >= 300 && words_sent < 550) || $urandom_range(99) >= 25)) begin
          next_word = stim_words.pop_front();
          in_opcode      <= next_word.op;
          in_rotor_angle <= next_word.angle;
          in_x           <= next_word.x;
          in_y           <= next_word.y;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result word against the oldest prediction.
  // Backpressure in about 25 percent of cycles, none for results 300..549.
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, logic signed [15:0] want,
                              logic signed [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: result %0d %s expected %0d actual %0d",
               results_seen, field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_phases.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result %0d: %0d %0d %0d",
                     results_seen, out_first, out_second, out_third);
        end else begin
          oldest_phase = expected_phases.pop_front();
          if (out_first !== oldest_phase.first)
            report_field("first", oldest_phase.first, out_first);
          if (out_second !== oldest_phase.second)
            report_field("second", oldest_phase.second, out_second);
          if (out_third !== oldest_phase.third)
            report_field("third", oldest_phase.third, out_third);
        end
        results_seen++;
      end
      out_ready <= (results_seen >= 300 && results_seen < 550) ||
                   ($urandom_range(99) >= 25);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, run all words, drain, then give the verdict
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_phases.size() != 0) @(posedge clk);
    // Pipeline is 17 deep; give stray words time to show up
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_phases.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: ends a hung run with a failing verdict
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
